/* src/sfdl_pkg.sv */
// ----------------------------------------------------------------------------
// sfdl_pkg
// Shared widths, register indexes, reset values, sequencer step codes and
// the control structs passed from the top level to each channel lane.
// ----------------------------------------------------------------------------
package sfdl_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int COEF_W     = 24;
	localparam int DLY_W      = 25;
	localparam int GAIN_W     = 15;
	localparam int WET_W      = 16;
	localparam int FRAC_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;
	localparam int MAX_CH     = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WET    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd6;

	// register reset values
	localparam int DELAY_RESET = 6144000;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd15565;
	localparam logic [WET_W-1:0]  WET_RESET  = 16'd16384;
	localparam logic [COEF_W-1:0] B0_RESET   = 24'sd90685;
	localparam logic [COEF_W-1:0] A1_RESET   = -24'sd6472376;
	localparam logic [COEF_W-1:0] A2_RESET   = 24'sd2640826;

	// sequencer steps
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] ST_IDLE = 5'd0;
	localparam logic [STEP_W-1:0] ST_ADR  = 5'd1;
	localparam logic [STEP_W-1:0] ST_RD1  = 5'd2;
	localparam logic [STEP_W-1:0] ST_RD2  = 5'd3;
	localparam logic [STEP_W-1:0] ST_LD2  = 5'd4;
	localparam logic [STEP_W-1:0] ST_MINT = 5'd5;
	localparam logic [STEP_W-1:0] ST_DLY  = 5'd6;
	localparam logic [STEP_W-1:0] ST_MFB  = 5'd7;
	localparam logic [STEP_W-1:0] ST_FBX  = 5'd8;
	localparam logic [STEP_W-1:0] ST_MB0  = 5'd9;
	localparam logic [STEP_W-1:0] ST_Y    = 5'd10;
	localparam logic [STEP_W-1:0] ST_MIX  = 5'd11;
	localparam logic [STEP_W-1:0] ST_ACC  = 5'd12;
	localparam logic [STEP_W-1:0] ST_E1   = 5'd13;
	localparam logic [STEP_W-1:0] ST_E2   = 5'd14;
	localparam logic [STEP_W-1:0] ST_Z2   = 5'd15;
	localparam logic [STEP_W-1:0] ST_OUT  = 5'd16;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic [FRAC_W-1:0] frac;
		logic              v1;
		logic              v2;
	} lane_ctl_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [WET_W-1:0]  wet;
		logic [WET_W-1:0]  dry;
		logic [COEF_W-1:0] b0;
		logic [COEF_W-1:0] a1;
		logic [COEF_W-1:0] a2;
	} coef_t;

endpackage

/* src/sfdl_if.sv */
// ----------------------------------------------------------------------------
// sfdl channel interfaces
// Valid/ready channels for input frames, output frames and register writes.
// ----------------------------------------------------------------------------
interface sfdl_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sfdl_pkg::SAMPLE_W-1:0] left_in;
	logic signed [sfdl_pkg::SAMPLE_W-1:0] right_in;

	modport source(output valid, output left_in, output right_in, input ready);
	modport sink(input valid, input left_in, input right_in, output ready);
endinterface

interface sfdl_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sfdl_pkg::SAMPLE_W-1:0] left_out;
	logic signed [sfdl_pkg::SAMPLE_W-1:0] right_out;

	modport source(output valid, output left_out, output right_out, input ready);
	modport sink(input valid, input left_out, input right_out, output ready);
endinterface

interface sfdl_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [sfdl_pkg::CFG_IDX_W-1:0]      index;
	logic [sfdl_pkg::CFG_DATA_W-1:0]     data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* src/sfdl_ram.sv */
// ----------------------------------------------------------------------------
// sfdl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sfdl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/sfdl_lane.sv */
// ----------------------------------------------------------------------------
// sfdl_lane
// One channel: delay ring memory, interpolation, feedback lowpass biquad and
// wet/dry mix, all stepped through a single shared multiplier.
// ----------------------------------------------------------------------------
module sfdl_lane #(
	parameter int RING_DEPTH = 131072
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sfdl_pkg::lane_ctl_t                  ctl,
	input  sfdl_pkg::coef_t                      coef,
	input  logic [$clog2(RING_DEPTH)-1:0]        rd_addr,
	input  logic [$clog2(RING_DEPTH)-1:0]        wr_addr,
	input  logic signed [sfdl_pkg::SAMPLE_W-1:0] smp,
	output logic signed [sfdl_pkg::SAMPLE_W-1:0] res
);

	localparam logic signed [51:0] RND8  = 52'sd128;
	localparam logic signed [51:0] RND15 = 52'sd16384;
	localparam logic signed [51:0] RND22 = 52'sd2097152;

	function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
		logic signed [23:0] r;
		if (v > 64'sd8388607) begin
			r = 24'sh7fffff;
		end else if (v < -64'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic [sfdl_pkg::SAMPLE_W-1:0]        rd_data;
	logic signed [sfdl_pkg::SAMPLE_W-1:0] rd_s;
	logic signed [sfdl_pkg::SAMPLE_W-1:0] wr_data;
	logic                                 wr_en;

	logic signed [23:0] s1_q;
	logic signed [23:0] y_q;
	logic signed [23:0] res_q;
	logic signed [24:0] diff_q;
	logic signed [24:0] delayed_q;
	logic signed [24:0] fbx_q;
	logic signed [51:0] prod_q;
	logic signed [51:0] p_q;
	logic signed [51:0] acc_q;
	logic signed [51:0] e_q;
	logic signed [31:0] z1_q;
	logic signed [31:0] z2_q;
	logic signed [25:0] mul_a;
	logic signed [25:0] mul_b;

	sfdl_ram #(
		.WIDTH(sfdl_pkg::SAMPLE_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign rd_s    = $signed(rd_data);
	assign wr_en   = (ctl.step == sfdl_pkg::ST_MIX);
	assign wr_data = sat24(64'(smp) + 64'(y_q));
	assign res     = res_q;

	// shared multiplier operand select
	always_comb begin
		case (ctl.step)
			sfdl_pkg::ST_MINT: begin
				mul_a = 26'(diff_q);
				mul_b = 26'(ctl.frac);
			end
			sfdl_pkg::ST_MFB: begin
				mul_a = 26'(delayed_q);
				mul_b = 26'(coef.gain);
			end
			sfdl_pkg::ST_MB0: begin
				mul_a = 26'($signed(coef.b0));
				mul_b = 26'(fbx_q);
			end
			sfdl_pkg::ST_Y: begin
				mul_a = 26'(smp);
				mul_b = 26'(coef.dry);
			end
			sfdl_pkg::ST_MIX: begin
				mul_a = 26'(delayed_q);
				mul_b = 26'(coef.wet);
			end
			sfdl_pkg::ST_ACC: begin
				mul_a = 26'($signed(coef.a1));
				mul_b = 26'(y_q);
			end
			sfdl_pkg::ST_E1: begin
				mul_a = 26'($signed(coef.a2));
				mul_b = 26'(y_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 52'(mul_a) * 52'(mul_b);
		case (ctl.step)
			sfdl_pkg::ST_RD2: begin
				s1_q <= ctl.v1 ? rd_s : 24'sd0;
			end
			sfdl_pkg::ST_LD2: begin
				diff_q <= (ctl.v2 ? 25'(rd_s) : 25'sd0) - 25'(s1_q);
			end
			sfdl_pkg::ST_DLY: begin
				delayed_q <= 25'(s1_q) + 25'((prod_q + RND8) >>> 8);
			end
			sfdl_pkg::ST_FBX: begin
				fbx_q <= 25'((prod_q + RND15) >>> 15);
			end
			sfdl_pkg::ST_Y: begin
				p_q <= prod_q;
				y_q <= sat24(64'((prod_q + RND22) >>> 22) + 64'(z1_q));
			end
			sfdl_pkg::ST_MIX: begin
				acc_q <= prod_q;
			end
			sfdl_pkg::ST_ACC: begin
				acc_q <= acc_q + prod_q;
			end
			sfdl_pkg::ST_E1: begin
				e_q   <= (p_q <<< 1) - prod_q + RND22;
				res_q <= sat24(64'((acc_q + RND15) >>> 15));
			end
			sfdl_pkg::ST_E2: begin
				e_q <= p_q - prod_q + RND22;
			end
			default: begin
			end
		endcase
	end

	// biquad state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z1_q <= '0;
			z2_q <= '0;
		end else begin
			case (ctl.step)
				sfdl_pkg::ST_E2: begin
					z1_q <= sat32(64'(e_q >>> 22) + 64'(z2_q));
				end
				sfdl_pkg::ST_Z2: begin
					z2_q <= sat32(64'(e_q >>> 22));
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* src/stereo_feedback_delay_lowpass_unit.sv */
// ----------------------------------------------------------------------------
// stereo_feedback_delay_lowpass_unit
// Stereo feedback delay with interpolated ring read and lowpass feedback.
//
//  channel  role      handshake             payload
//  feed     item in   valid/ready           left_in, right_in
//  mix      item out  valid/ready           left_out, right_out
//  cfg      reg write valid/ready (ready=1) index, data
//
// Between one accepted frame and the next, each lane steps its single
// multiplier through interpolation, gain, biquad and mix in sequence. A
// bypassed frame goes straight from accept to the output step. The output
// register lets the next frame be accepted while a result waits; a stalled
// result holds the lanes at the end. No clearing pass after reset: ring
// entries not yet written read as zero. A delay write on a ring shorter than
// 2^17 entries runs a modulo reduction, during which no frame is accepted.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_lowpass_unit #(
	parameter int RING_DEPTH = 131072,
	parameter int CHANNELS   = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	sfdl_in_if.sink       feed,
	sfdl_out_if.source    mix,
	sfdl_cfg_if.sink      cfg
);

	localparam int AW         = $clog2(RING_DEPTH);
	localparam int SPAN       = RING_DEPTH * 256;
	localparam int PW         = AW + 9;
	localparam int FL         = $clog2(SPAN + 1) - 1;
	localparam int RED_STEPS  = (FL >= sfdl_pkg::DLY_W) ? 0 : sfdl_pkg::DLY_W - FL;
	localparam int RCW        = (RED_STEPS > 0) ? $clog2(RED_STEPS + 1) : 1;
	localparam int RW         = sfdl_pkg::DLY_W + 2;
	localparam int DMOD_RESET = sfdl_pkg::DELAY_RESET % SPAN;

	localparam logic [PW-1:0] SPAN_P   = PW'(SPAN);
	localparam logic [RW-1:0] RED_BASE = RW'(SPAN);
	localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
	localparam logic [sfdl_pkg::WET_W-1:0] UNITY = 16'd32768;

	// control state
	logic [sfdl_pkg::STEP_W-1:0] state_q;
	logic [AW-1:0]               wp_q;
	logic                        wrapped_q;
	logic                        ov_q;

	// registers
	logic                          bypass_q;
	logic [sfdl_pkg::DLY_W-1:0]    dmod_q;
	logic [RCW-1:0]                red_cnt_q;
	logic [sfdl_pkg::GAIN_W-1:0]   gain_q;
	logic [sfdl_pkg::WET_W-1:0]    wet_q;
	logic [sfdl_pkg::COEF_W-1:0]   b0_q;
	logic [sfdl_pkg::COEF_W-1:0]   a1_q;
	logic [sfdl_pkg::COEF_W-1:0]   a2_q;

	// item payload
	logic signed [sfdl_pkg::SAMPLE_W-1:0] smp_q [sfdl_pkg::MAX_CH];
	logic signed [sfdl_pkg::SAMPLE_W-1:0] res   [sfdl_pkg::MAX_CH];
	logic signed [sfdl_pkg::SAMPLE_W-1:0] out_l_q;
	logic signed [sfdl_pkg::SAMPLE_W-1:0] out_r_q;
	logic [PW-1:0]                 pos_q;
	logic [AW-1:0]                 i1_q;
	logic [AW-1:0]                 i2_q;
	logic [sfdl_pkg::FRAC_W-1:0]   frac_q;
	logic                          v1_q;
	logic                          v2_q;

	logic                          feed_acc;
	logic                          load_out;
	logic                          cfg_wr;
	logic [PW-1:0]                 pos_raw;
	logic [PW-1:0]                 pos_w;
	logic [RW-1:0]                 red_thr;
	logic [sfdl_pkg::WET_W-1:0]    wet_c;
	logic [AW-1:0]                 rd_addr;
	sfdl_pkg::coef_t               coef;
	sfdl_pkg::lane_ctl_t           ctl;

	assign feed.ready = (state_q == sfdl_pkg::ST_IDLE) && (red_cnt_q == '0);
	assign feed_acc   = feed.valid && feed.ready;
	assign load_out   = (state_q == sfdl_pkg::ST_OUT) && (!ov_q || mix.ready);
	assign cfg.ready  = 1'b1;
	assign cfg_wr     = cfg.valid && cfg.ready;

	assign mix.valid     = ov_q;
	assign mix.left_out  = out_l_q;
	assign mix.right_out = out_r_q;

	// read position behind the write pointer
	assign pos_raw = PW'({wp_q, 8'h00}) + SPAN_P - PW'(dmod_q);
	assign pos_w   = (pos_q >= SPAN_P) ? pos_q - SPAN_P : pos_q;
	assign red_thr = RED_BASE << (red_cnt_q - RCW'(1));

	assign wet_c = (wet_q > UNITY) ? UNITY : wet_q;
	assign coef  = '{gain: gain_q, wet: wet_c, dry: UNITY - wet_c,
		b0: b0_q, a1: a1_q, a2: a2_q};
	assign ctl   = '{step: state_q, frac: frac_q, v1: v1_q, v2: v2_q};
	assign rd_addr = (state_q == sfdl_pkg::ST_RD1) ? i1_q : i2_q;

	for (genvar c = 0; c < sfdl_pkg::MAX_CH; c++) begin : g_ch
		if (c < CHANNELS) begin : g_lane
			sfdl_lane #(
				.RING_DEPTH(RING_DEPTH)
			) u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.coef   (coef),
				.rd_addr(rd_addr),
				.wr_addr(wp_q),
				.smp    (smp_q[c]),
				.res    (res[c])
			);
		end else begin : g_pass
			assign res[c] = smp_q[c];
		end
	end

	// register writes and delay modulo reduction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q  <= 1'b0;
			dmod_q    <= sfdl_pkg::DLY_W'(DMOD_RESET);
			red_cnt_q <= '0;
			gain_q    <= sfdl_pkg::GAIN_RESET;
			wet_q     <= sfdl_pkg::WET_RESET;
			b0_q      <= sfdl_pkg::B0_RESET;
			a1_q      <= sfdl_pkg::A1_RESET;
			a2_q      <= sfdl_pkg::A2_RESET;
		end else if (cfg_wr) begin
			case (cfg.index)
				sfdl_pkg::REG_BYPASS: bypass_q <= cfg.data[0];
				sfdl_pkg::REG_DELAY: begin
					dmod_q    <= cfg.data[sfdl_pkg::DLY_W-1:0];
					red_cnt_q <= RCW'(RED_STEPS);
				end
				sfdl_pkg::REG_GAIN: gain_q <= cfg.data[sfdl_pkg::GAIN_W-1:0];
				sfdl_pkg::REG_WET:  wet_q  <= cfg.data[sfdl_pkg::WET_W-1:0];
				sfdl_pkg::REG_B0:   b0_q   <= cfg.data[sfdl_pkg::COEF_W-1:0];
				sfdl_pkg::REG_A1:   a1_q   <= cfg.data[sfdl_pkg::COEF_W-1:0];
				sfdl_pkg::REG_A2:   a2_q   <= cfg.data[sfdl_pkg::COEF_W-1:0];
				default: begin
				end
			endcase
		end else if (red_cnt_q != '0) begin
			if (RW'(dmod_q) >= red_thr) begin
				dmod_q <= dmod_q - sfdl_pkg::DLY_W'(red_thr);
			end
			red_cnt_q <= red_cnt_q - RCW'(1);
		end
	end

	// sequencer, write pointer, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sfdl_pkg::ST_IDLE;
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (mix.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				sfdl_pkg::ST_IDLE: begin
					if (feed_acc) begin
						state_q <= bypass_q ? sfdl_pkg::ST_OUT : sfdl_pkg::ST_ADR;
					end
				end
				sfdl_pkg::ST_ADR, sfdl_pkg::ST_RD1, sfdl_pkg::ST_RD2,
				sfdl_pkg::ST_LD2, sfdl_pkg::ST_MINT, sfdl_pkg::ST_DLY,
				sfdl_pkg::ST_MFB, sfdl_pkg::ST_FBX, sfdl_pkg::ST_MB0,
				sfdl_pkg::ST_Y, sfdl_pkg::ST_MIX, sfdl_pkg::ST_ACC,
				sfdl_pkg::ST_E1, sfdl_pkg::ST_E2, sfdl_pkg::ST_Z2: begin
					state_q <= state_q + 1'b1;
				end
				sfdl_pkg::ST_OUT: begin
					if (load_out) begin
						state_q <= sfdl_pkg::ST_IDLE;
						if (!bypass_q) begin
							if (wp_q == LAST_IDX) begin
								wp_q      <= '0;
								wrapped_q <= 1'b1;
							end else begin
								wp_q <= wp_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= sfdl_pkg::ST_IDLE;
			endcase
		end
	end

	// item payload and addressing
	always_ff @(posedge clk) begin
		if (feed_acc) begin
			smp_q[0] <= feed.left_in;
			smp_q[1] <= feed.right_in;
			pos_q    <= pos_raw;
		end
		case (state_q)
			sfdl_pkg::ST_ADR: begin
				i1_q   <= pos_w[AW+7:8];
				frac_q <= pos_w[7:0];
			end
			sfdl_pkg::ST_RD1: begin
				i2_q <= (i1_q == LAST_IDX) ? '0 : i1_q + 1'b1;
				v1_q <= wrapped_q || (i1_q < wp_q);
			end
			sfdl_pkg::ST_RD2: begin
				v2_q <= wrapped_q || (i2_q < wp_q);
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_l_q <= bypass_q ? smp_q[0] : res[0];
			out_r_q <= bypass_q ? smp_q[1] : res[1];
		end
	end

	// checks
	a_wp_moves_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(wp_q) |-> $past(state_q == sfdl_pkg::ST_OUT))
		else $error("write pointer moved outside result load");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfdl_pkg::ST_IDLE) && !feed_acc |=> (state_q == sfdl_pkg::ST_IDLE))
		else $error("sequencer left idle without an accepted item");

	a_no_write_when_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfdl_pkg::ST_MIX) |-> (!bypass_q && (red_cnt_q == '0)))
		else $error("ring write while bypassed or delay not reduced");

	a_neighbor_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfdl_pkg::ST_RD2) |->
		((i2_q == AW'(i1_q + 1'b1)) || (i2_q == '0)))
		else $error("second neighbor index not adjacent");

endmodule

/* test/stereo_feedback_delay_lowpass_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_feedback_delay_lowpass_unit_tb
// Drives stereo frames and register writes into the feedback delay and checks
// every output frame against a bit-true predictor of the ring read, the
// interpolation, the lowpass biquad in the feedback path and the dry/wet mix,
// or against fixed expected values on directed rows that give them. A short
// directed table covers reset behavior, extremes, sub-sample and wrapping
// delays, overdriven mix and bypass. Random register settings then alternate
// with random frames, under random idling on both sides, one long output
// stall and one stretch with no idling at all.
module stereo_feedback_delay_lowpass_unit_tb;

	localparam int RING_LEN = 131072;
	localparam longint SPAN = longint'(RING_LEN) * 256;
	localparam longint Z_MAX = longint'(2147483647);
	localparam longint Z_MIN = -Z_MAX - 1;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASES = 10;
	localparam int FRAMES_PER_PHASE = 80;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [sfdl_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef enum logic [1:0] {ROW_WRITE, ROW_FRAME, ROW_KNOWN} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [sfdl_pkg::CFG_IDX_W-1:0]  idx;
		logic [sfdl_pkg::CFG_DATA_W-1:0] data;
		logic signed [23:0]              left;
		logic signed [23:0]              right;
		logic signed [23:0]              want_left;
		logic signed [23:0]              want_right;
	} stim_row_t;

	typedef struct {
		logic signed [23:0] left;
		logic signed [23:0] right;
	} mix_frame_t;

	localparam int PLAN_LEN = 44;
	stim_row_t plan [PLAN_LEN] = '{
		'{ROW_KNOWN, '0, '0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_KNOWN, '0, '0, 24'sh7FFFFF, 24'sh800000, 24'sd4194304, -24'sd4194304},
		'{ROW_KNOWN, '0, '0, 24'sh800000, 24'sh7FFFFF, -24'sd4194304, 24'sd4194304},
		'{ROW_KNOWN, '0, '0, 24'sd1, -24'sd1, 24'sd1, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_WET, 25'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_KNOWN, '0, '0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000},
		'{ROW_WRITE, sfdl_pkg::REG_DELAY, 25'd256, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_WET, 25'd32768, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_KNOWN, '0, '0, 24'sd0, 24'sd0, 24'sh7FFFFF, 24'sh800000},
		'{ROW_WRITE, sfdl_pkg::REG_DELAY, 25'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_WET, 25'd65535, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_FRAME, '0, '0, 24'sd123456, -24'sd654321, 24'sd0, 24'sd0},
		'{ROW_FRAME, '0, '0, 24'sh7FFFFF, 24'sh800000, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_DELAY, 25'd128, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_FRAME, '0, '0, 24'sh800000, 24'sh7FFFFF, 24'sd0, 24'sd0},
		'{ROW_FRAME, '0, '0, 24'sh2AAAAA, 24'sh555555, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_GAIN, 25'd32767, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_B0, 25'h07FFFFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_A1, 25'h0800000, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_A2, 25'h07FFFFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_FRAME, '0, '0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sd0, 24'sd0},
		'{ROW_FRAME, '0, '0, 24'sh800000, 24'sh800000, 24'sd0, 24'sd0},
		'{ROW_FRAME, '0, '0, 24'sh7FFFFF, 24'sh800000, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_B0, 25'h0800000, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_DELAY, 25'h1FFFF00, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_FRAME, '0, '0, 24'sh7FFFFF, 24'sh000001, 24'sd0, 24'sd0},
		'{ROW_FRAME, '0, '0, 24'sh800000, 24'shFFFFFF, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_DELAY, 25'h1FFFFFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_FRAME, '0, '0, 24'sh400000, 24'shC00000, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_BYPASS, 25'd1, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_KNOWN, '0, '0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000},
		'{ROW_KNOWN, '0, '0, -24'sd1, 24'sd1, -24'sd1, 24'sd1},
		'{ROW_WRITE, REG_SPARE, 25'h1FFFFFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_BYPASS, 25'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_GAIN, 25'(sfdl_pkg::GAIN_RESET),
			24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_WET, 25'(sfdl_pkg::WET_RESET),
			24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_B0, 25'(sfdl_pkg::B0_RESET),
			24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_A1, 25'(sfdl_pkg::A1_RESET),
			24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_A2, 25'(sfdl_pkg::A2_RESET),
			24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_WRITE, sfdl_pkg::REG_DELAY, 25'd1000, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_FRAME, '0, '0, 24'sh7FFFFF, 24'sh800000, 24'sd0, 24'sd0},
		'{ROW_FRAME, '0, '0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{ROW_FRAME, '0, '0, 24'sd123456, -24'sd123456, 24'sd0, 24'sd0},
		'{ROW_FRAME, '0, '0, 24'sh800000, 24'sh7FFFFF, 24'sd0, 24'sd0}
	};

	logic clk;
	logic arst_n;

	sfdl_in_if  feed_if();
	sfdl_out_if mix_if();
	sfdl_cfg_if cfg_if();

	stereo_feedback_delay_lowpass_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed_if),
		.mix    (mix_if),
		.cfg    (cfg_if)
	);

	// predictor state
	logic signed [23:0] echo_ring [2][RING_LEN];
	int unsigned        echo_wr;
	longint             lp_state [4];
	logic               byp;
	logic [24:0]        dly_q8;
	logic [14:0]        fb_gain;
	logic [15:0]        wet_mix;
	logic signed [23:0] lp_b0;
	logic signed [23:0] lp_a1;
	logic signed [23:0] lp_a2;

	mix_frame_t pending_mix [$];
	mix_frame_t head;

	int  n_frames;
	int  n_checked;
	int  n_writes;
	int  n_errors;
	int  hold_tickets;
	int  holds_done;
	bit  steady;

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic void reset_echo();
		foreach (echo_ring[c, i])
			echo_ring[c][i] = '0;
		foreach (lp_state[k])
			lp_state[k] = 0;
		echo_wr = 0;
		byp     = 1'b0;
		dly_q8  = 25'(sfdl_pkg::DELAY_RESET);
		fb_gain = sfdl_pkg::GAIN_RESET;
		wet_mix = sfdl_pkg::WET_RESET;
		lp_b0   = sfdl_pkg::B0_RESET;
		lp_a1   = sfdl_pkg::A1_RESET;
		lp_a2   = sfdl_pkg::A2_RESET;
	endfunction

	function automatic void apply_reg(logic [sfdl_pkg::CFG_IDX_W-1:0] idx,
			logic [sfdl_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			sfdl_pkg::REG_BYPASS: byp     = val[0];
			sfdl_pkg::REG_DELAY:  dly_q8  = val[24:0];
			sfdl_pkg::REG_GAIN:   fb_gain = val[14:0];
			sfdl_pkg::REG_WET:    wet_mix = val[15:0];
			sfdl_pkg::REG_B0:     lp_b0   = val[23:0];
			sfdl_pkg::REG_A1:     lp_a1   = val[23:0];
			sfdl_pkg::REG_A2:     lp_a2   = val[23:0];
			default:    ;
		endcase
	endfunction

	// one channel: interpolated ring read, lowpass feedback, ring write, mix
	function automatic logic signed [23:0] lane_echo(int ch, logic signed [23:0] x);
		longint pos, s1, s2, f, delayed, fbx, y, b0, a1, a2, wet, acc, xin, g;
		int i1, i2;
		pos = (longint'(echo_wr) * 256 + SPAN - (longint'(dly_q8) % SPAN)) % SPAN;
		i1 = int'(pos >>> 8);
		i2 = (i1 + 1) % RING_LEN;
		f  = pos & 255;
		s1 = echo_ring[ch][i1];
		s2 = echo_ring[ch][i2];
		delayed = s1 + round_shift((s2 - s1) * f, 8);
		g   = fb_gain;
		fbx = round_shift(delayed * g, 15);
		b0 = lp_b0;
		a1 = lp_a1;
		a2 = lp_a2;
		y = clamp(round_shift(b0 * fbx, 22) + lp_state[2*ch], -8388608, 8388607);
		lp_state[2*ch] = clamp(round_shift(2 * b0 * fbx - a1 * y, 22) + lp_state[2*ch+1],
			Z_MIN, Z_MAX);
		lp_state[2*ch+1] = clamp(round_shift(b0 * fbx - a2 * y, 22), Z_MIN, Z_MAX);
		xin = x;
		echo_ring[ch][echo_wr] = 24'(clamp(xin + y, -8388608, 8388607));
		wet = (wet_mix > 16'd32768) ? 32768 : longint'(wet_mix);
		acc = xin * (32768 - wet) + delayed * wet;
		return 24'(clamp(round_shift(acc, 15), -8388608, 8388607));
	endfunction

	function automatic mix_frame_t predict_frame(logic signed [23:0] l, logic signed [23:0] r);
		mix_frame_t res;
		res.left  = l;
		res.right = r;
		if (!byp) begin
			res.left  = lane_echo(0, l);
			res.right = lane_echo(1, r);
			echo_wr = (echo_wr + 1) % RING_LEN;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (n_errors < 30)
			$display("MISMATCH %s at %0t: got %0d, expected %0d", what, $time, got, want);
		n_errors++;
	endtask

	// called at a falling edge; returns at the falling edge after the write
	task automatic write_reg(input logic [sfdl_pkg::CFG_IDX_W-1:0] idx,
			input logic [sfdl_pkg::CFG_DATA_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		apply_reg(idx, val);
		n_writes++;
		@(negedge clk);
	endtask

	task automatic push_frame(input logic signed [23:0] l, input logic signed [23:0] r,
			input bit known, input logic signed [23:0] wl, input logic signed [23:0] wr);
		mix_frame_t want;
		cfg_if.valid <= 1'b0;
		while (!steady && $urandom_range(0, 99) < 30) begin
			feed_if.valid <= 1'b0;
			@(negedge clk);
		end
		feed_if.valid    <= 1'b1;
		feed_if.left_in  <= l;
		feed_if.right_in <= r;
		@(posedge clk);
		while (!feed_if.ready)
			@(posedge clk);
		want = predict_frame(l, r);
		if (known) begin
			want.left  = wl;
			want.right = wr;
		end
		pending_mix.push_back(want);
		n_frames++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		feed_if.valid <= 1'b0;
		while (pending_mix.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [23:0] pick_sample();
		int roll;
		roll = $urandom_range(0, 19);
		case (roll)
			0:       return 24'sh7FFFFF;
			1:       return 24'sh800000;
			2:       return 24'sd0;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic random_setting(input int phase);
		logic [sfdl_pkg::CFG_DATA_W-1:0] v;
		int roll;
		wait_idle();
		write_reg(sfdl_pkg::REG_BYPASS,
			(phase == 6 || $urandom_range(0, 11) == 0) ? 25'd1 : 25'd0);
		roll = $urandom_range(0, 9);
		if (roll < 6)
			v = 25'($urandom_range(0, 64 * 256));
		else if (roll < 8)
			v = 25'($urandom_range(0, 4000 * 256));
		else if (roll < 9)
			v = 25'h1FFFFFF - 25'($urandom_range(0, 2048));
		else
			v = 25'($urandom);
		write_reg(sfdl_pkg::REG_DELAY, v);
		roll = $urandom_range(0, 9);
		v = (roll < 2) ? 25'd31130 : ((roll < 3) ? 25'd32767 : 25'($urandom_range(0, 32767)));
		write_reg(sfdl_pkg::REG_GAIN, v);
		roll = $urandom_range(0, 9);
		if (roll < 2)
			v = 25'($urandom_range(32769, 65535));
		else if (roll < 3)
			v = 25'd32768;
		else
			v = 25'($urandom_range(0, 32768));
		write_reg(sfdl_pkg::REG_WET, v);
		if ($urandom_range(0, 1)) begin
			write_reg(sfdl_pkg::REG_B0, 25'(sfdl_pkg::B0_RESET ^ 24'($urandom_range(0, 255))));
			write_reg(sfdl_pkg::REG_A1, 25'(sfdl_pkg::A1_RESET ^ 24'($urandom_range(0, 255))));
			write_reg(sfdl_pkg::REG_A2, 25'(sfdl_pkg::A2_RESET ^ 24'($urandom_range(0, 255))));
		end else begin
			write_reg(sfdl_pkg::REG_B0, 25'(24'($urandom)));
			write_reg(sfdl_pkg::REG_A1, 25'(24'($urandom)));
			write_reg(sfdl_pkg::REG_A2, 25'(24'($urandom)));
		end
	endtask

	// output side: random stalls, one long hold-off on request
	initial begin
		mix_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_tickets != holds_done) begin
				holds_done++;
				mix_if.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
			end else begin
				mix_if.ready <= steady || ($urandom_range(0, 99) >= 30);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && mix_if.valid && mix_if.ready) begin
			if (pending_mix.size() == 0) begin
				report_mismatch("unexpected item left_out", mix_if.left_out, 0);
			end else begin
				head = pending_mix.pop_front();
				n_checked++;
				if (mix_if.left_out !== head.left)
					report_mismatch("left_out", mix_if.left_out, head.left);
				if (mix_if.right_out !== head.right)
					report_mismatch("right_out", mix_if.right_out, head.right);
			end
		end
	end

	initial begin
		int stall_count;
		stall_count = 0;
		while (stall_count < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (feed_if.valid && feed_if.ready) || (mix_if.valid && mix_if.ready)
					|| (cfg_if.valid && cfg_if.ready))
				stall_count = 0;
			else
				stall_count++;
		end
		$display("watchdog: no item moved for %0d cycles, %0d results outstanding",
			STALL_LIMIT, pending_mix.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin
		bit prev_write;
		n_frames     = 0;
		n_checked    = 0;
		n_writes     = 0;
		n_errors     = 0;
		hold_tickets = 0;
		holds_done   = 0;
		steady       = 1'b0;
		prev_write   = 1'b0;
		arst_n           <= 1'b0;
		feed_if.valid    <= 1'b0;
		feed_if.left_in  <= '0;
		feed_if.right_in <= '0;
		cfg_if.valid     <= 1'b0;
		cfg_if.index     <= '0;
		cfg_if.data      <= '0;
		reset_echo();
		repeat (8)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int k = 0; k < PLAN_LEN; k++) begin
			if (plan[k].kind == ROW_WRITE) begin
				if (!prev_write)
					wait_idle();
				write_reg(plan[k].idx, plan[k].data);
				prev_write = 1'b1;
			end else begin
				push_frame(plan[k].left, plan[k].right, plan[k].kind == ROW_KNOWN,
					plan[k].want_left, plan[k].want_right);
				prev_write = 1'b0;
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			random_setting(p);
			if (p == 1)
				steady <= 1'b1;
			if (p == 3)
				hold_tickets <= hold_tickets + 1;
			for (int n = 0; n < FRAMES_PER_PHASE; n++)
				push_frame(pick_sample(), pick_sample(), 1'b0, 24'sd0, 24'sd0);
			steady <= 1'b0;
		end

		wait_idle();
		repeat (DRAIN_CYCLES)
			@(negedge clk);

		$display("covered %0d frames and %0d register writes: bypass, sub-sample and wrapping",
			n_frames, n_writes);
		$display("delays, overdriven mix, saturating feedback; %0d results compared, %0d errors",
			n_checked, n_errors);
		if (n_errors == 0 && pending_mix.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
